// ===== design/mcl_pkg.sv =====
// ----------------------------------------------------------------------------
// mcl_pkg: shared types and constants for the monochrome LCD controller
// Request codes, decoded command codes, command byte values, frame store
// geometry and the structures that pass between the front, back and RAM.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mcl_pkg;

  // Request kinds as carried on the input tuser.
  localparam logic [1:0] REQ_CMD  = 2'd0;
  localparam logic [1:0] REQ_DATA = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;
  localparam logic [1:0] REQ_RSVD = 2'd3;

  // Decoded command codes.
  localparam int unsigned CMD_W = 5;
  localparam logic [CMD_W-1:0] CMD_OTHER     = 5'd0;
  localparam logic [CMD_W-1:0] CMD_RESET     = 5'd1;
  localparam logic [CMD_W-1:0] CMD_DISP_OFF  = 5'd2;
  localparam logic [CMD_W-1:0] CMD_DISP_ON   = 5'd3;
  localparam logic [CMD_W-1:0] CMD_ALL_OFF   = 5'd4;
  localparam logic [CMD_W-1:0] CMD_ALL_ON    = 5'd5;
  localparam logic [CMD_W-1:0] CMD_INV_OFF   = 5'd6;
  localparam logic [CMD_W-1:0] CMD_INV_ON    = 5'd7;
  localparam logic [CMD_W-1:0] CMD_SEG_NORM  = 5'd8;
  localparam logic [CMD_W-1:0] CMD_SEG_REV   = 5'd9;
  localparam logic [CMD_W-1:0] CMD_COM_NORM  = 5'd10;
  localparam logic [CMD_W-1:0] CMD_COM_REV   = 5'd11;
  localparam logic [CMD_W-1:0] CMD_SKIP      = 5'd12;
  localparam logic [CMD_W-1:0] CMD_START     = 5'd13;
  localparam logic [CMD_W-1:0] CMD_PAGE      = 5'd14;
  localparam logic [CMD_W-1:0] CMD_COL_LO    = 5'd15;
  localparam logic [CMD_W-1:0] CMD_COL_HI    = 5'd16;

  // Command byte values.
  localparam logic [7:0] BYTE_RESET    = 8'hE2;
  localparam logic [7:0] BYTE_DISP_OFF = 8'hAE;
  localparam logic [7:0] BYTE_DISP_ON  = 8'hAF;
  localparam logic [7:0] BYTE_ALL_OFF  = 8'hA4;
  localparam logic [7:0] BYTE_ALL_ON   = 8'hA5;
  localparam logic [7:0] BYTE_INV_OFF  = 8'hA6;
  localparam logic [7:0] BYTE_INV_ON   = 8'hA7;
  localparam logic [7:0] BYTE_SEG_NORM = 8'hA0;
  localparam logic [7:0] BYTE_SEG_REV  = 8'hA1;
  localparam logic [7:0] BYTE_COM_NORM = 8'hC0;
  localparam logic [7:0] BYTE_COM_REV  = 8'hC8;
  localparam logic [7:0] BYTE_SKIP     = 8'h81;

  // Frame store geometry: 8 pages of 128 columns, one byte per column.
  localparam int unsigned SCREEN_COLUMNS = 128;
  localparam int unsigned SCREEN_ROWS    = 64;
  localparam int unsigned STORE_BYTES    = 1024;
  localparam int unsigned STORE_AW       = $clog2(STORE_BYTES);

  // One queued request.
  typedef struct packed {
    logic [1:0]       kind;
    logic [CMD_W-1:0] cmd;
    logic [7:0]       arg;
    logic [6:0]       x;
    logic [5:0]       y;
  } mcl_item_t;

  // Frame store access from the back end.
  typedef struct packed {
    logic                we;
    logic [STORE_AW-1:0] waddr;
    logic [7:0]          wdata;
    logic                re;
    logic [STORE_AW-1:0] raddr;
  } mcl_ram_req_t;

endpackage

`default_nettype wire

// ===== design/mcl_ram.sv =====
// ----------------------------------------------------------------------------
// mcl_ram: generic single-clock RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mcl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/mcl_front.sv =====
// ----------------------------------------------------------------------------
// mcl_front: request intake and command classification
// Decodes each accepted request and holds it in a short queue for the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mcl_front #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output      logic               s_tready,
  input  wire logic [23:0]        s_tdata,
  input  wire logic [1:0]         s_tuser,
  input  wire logic               busy_clear,
  output      logic               q_valid,
  output      mcl_pkg::mcl_item_t q_item,
  input  wire logic               q_ready
);

  import mcl_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  mcl_item_t        entry [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  mcl_item_t        item_in;
  logic [CMD_W-1:0] cmd_code;
  logic             push;
  logic             pop;

  always_comb begin
    unique case (s_tdata[7:0]) inside
      BYTE_RESET:       cmd_code = CMD_RESET;
      BYTE_DISP_OFF:    cmd_code = CMD_DISP_OFF;
      BYTE_DISP_ON:     cmd_code = CMD_DISP_ON;
      BYTE_ALL_OFF:     cmd_code = CMD_ALL_OFF;
      BYTE_ALL_ON:      cmd_code = CMD_ALL_ON;
      BYTE_INV_OFF:     cmd_code = CMD_INV_OFF;
      BYTE_INV_ON:      cmd_code = CMD_INV_ON;
      BYTE_SEG_NORM:    cmd_code = CMD_SEG_NORM;
      BYTE_SEG_REV:     cmd_code = CMD_SEG_REV;
      BYTE_COM_NORM:    cmd_code = CMD_COM_NORM;
      BYTE_COM_REV:     cmd_code = CMD_COM_REV;
      BYTE_SKIP:        cmd_code = CMD_SKIP;
      [8'h40:8'h7F]:    cmd_code = CMD_START;
      [8'hB0:8'hB7]:    cmd_code = CMD_PAGE;
      [8'h00:8'h0F]:    cmd_code = CMD_COL_LO;
      [8'h10:8'h1F]:    cmd_code = CMD_COL_HI;
      default:          cmd_code = CMD_OTHER;
    endcase
  end

  assign item_in.kind = s_tuser;
  assign item_in.cmd  = cmd_code;
  assign item_in.arg  = s_tdata[7:0];
  assign item_in.x    = s_tdata[14:8];
  assign item_in.y    = s_tdata[20:15];

  // The queue takes nothing while the frame store is being cleared.
  assign s_tready = !busy_clear && (count != CW'(DEPTH));
  // Reserved request codes are accepted and dropped here.
  assign push     = s_tvalid && s_tready && (s_tuser != REQ_RSVD);
  assign q_valid  = (count != '0);
  assign q_item   = entry[rd_ptr];
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/mcl_back.sv =====
// ----------------------------------------------------------------------------
// mcl_back: command execution, frame store access and pixel readout
// Applies queued requests in order, clears the frame store and forms pixels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mcl_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 panel_flip,
  input  wire logic                 q_valid,
  input  wire mcl_pkg::mcl_item_t   q_item,
  output      logic                 q_ready,
  output      logic                 busy_clear,
  output      mcl_pkg::mcl_ram_req_t ram_req,
  input  wire logic [7:0]           ram_rdata,
  output      logic                 pix_valid,
  output      logic                 pix_on,
  input  wire logic                 pix_ready
);

  import mcl_pkg::*;

  logic [2:0]          page;
  logic [7:0]          column;
  logic [3:0]          col_lo;
  logic [3:0]          col_hi;
  logic [5:0]          start_line;
  logic                disp_en;
  logic                invert;
  logic                all_on;
  logic                seg_rev;
  logic                com_rev;
  logic                skip;
  logic [STORE_AW-1:0] clr_cnt;
  logic                rd_pend;
  logic [2:0]          rd_bit;
  logic                rd_all_on;
  logic                rd_disp_en;
  logic                rd_invert;

  logic                take;
  logic                is_cmd;
  logic                is_data;
  logic                is_read;
  logic [5:0]          sy;
  logic [6:0]          sx;
  logic                data_wr;
  logic                lit;

  assign is_cmd  = q_item.kind == REQ_CMD;
  assign is_data = q_item.kind == REQ_DATA;
  assign is_read = q_item.kind == REQ_READ;

  // A read issues only when its result has a free output slot next cycle.
  assign q_ready = !busy_clear &&
                   (!is_read || (!rd_pend && (!pix_valid || pix_ready)));
  assign take    = q_valid && q_ready;

  // Screen to store mapping: scroll by start line, then the reversals.
  always_comb begin
    sy = q_item.y + start_line;
    if (com_rev) begin
      sy = ~sy;
    end
    sx = q_item.x;
    if (seg_rev ^ panel_flip) begin
      sx = ~sx;
    end
  end

  assign data_wr = take && is_data && !skip && !column[7];

  always_comb begin
    if (busy_clear) begin
      ram_req.we    = 1'b1;
      ram_req.waddr = clr_cnt;
      ram_req.wdata = '0;
    end else begin
      ram_req.we    = data_wr;
      ram_req.waddr = {page, column[6:0]};
      ram_req.wdata = q_item.arg;
    end
    ram_req.re    = take && is_read;
    ram_req.raddr = {sy[5:3], sx};
  end

  always_comb begin
    lit = ram_rdata[rd_bit];
    if (rd_all_on) begin
      lit = 1'b1;
    end
    if (!rd_disp_en) begin
      lit = 1'b0;
    end
    lit = lit ^ rd_invert;
  end

  always_ff @(posedge clk) begin
    if (take && is_read) begin
      rd_bit     <= sy[2:0];
      rd_all_on  <= all_on;
      rd_disp_en <= disp_en;
      rd_invert  <= invert;
    end
    if (rd_pend) begin
      pix_on <= lit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      page       <= '0;
      column     <= '0;
      col_lo     <= '0;
      col_hi     <= '0;
      start_line <= '0;
      disp_en    <= 1'b1;
      invert     <= 1'b0;
      all_on     <= 1'b0;
      seg_rev    <= 1'b0;
      com_rev    <= 1'b0;
      skip       <= 1'b0;
      busy_clear <= 1'b1;
      clr_cnt    <= '0;
      rd_pend    <= 1'b0;
      pix_valid  <= 1'b0;
    end else begin
      rd_pend <= take && is_read;
      if (rd_pend) begin
        pix_valid <= 1'b1;
      end else if (pix_ready) begin
        pix_valid <= 1'b0;
      end

      if (busy_clear) begin
        clr_cnt <= clr_cnt + 1'b1;
        if (clr_cnt == STORE_AW'(STORE_BYTES - 1)) begin
          busy_clear <= 1'b0;
        end
      end

      if (take && (is_cmd || is_data) && skip) begin
        // The byte after the skip command is swallowed whatever it is.
        skip <= 1'b0;
      end else if (take && is_data) begin
        if (!column[7]) begin
          column <= {1'b0, column[6:0] + 7'd1};
        end
      end else if (take && is_cmd) begin
        unique case (q_item.cmd)
          CMD_RESET: begin
            page       <= '0;
            column     <= '0;
            col_lo     <= '0;
            col_hi     <= '0;
            start_line <= '0;
            disp_en    <= 1'b1;
            invert     <= 1'b0;
            all_on     <= 1'b0;
            seg_rev    <= 1'b0;
            com_rev    <= 1'b0;
            busy_clear <= 1'b1;
            clr_cnt    <= '0;
          end
          CMD_DISP_OFF: disp_en    <= 1'b0;
          CMD_DISP_ON:  disp_en    <= 1'b1;
          CMD_ALL_OFF:  all_on     <= 1'b0;
          CMD_ALL_ON:   all_on     <= 1'b1;
          CMD_INV_OFF:  invert     <= 1'b0;
          CMD_INV_ON:   invert     <= 1'b1;
          CMD_SEG_NORM: seg_rev    <= 1'b0;
          CMD_SEG_REV:  seg_rev    <= 1'b1;
          CMD_COM_NORM: com_rev    <= 1'b0;
          CMD_COM_REV:  com_rev    <= 1'b1;
          CMD_SKIP:     skip       <= 1'b1;
          CMD_START:    start_line <= q_item.arg[5:0];
          CMD_PAGE:     page       <= q_item.arg[2:0];
          CMD_COL_LO: begin
            col_lo <= q_item.arg[3:0];
            column <= {col_hi, q_item.arg[3:0]};
          end
          CMD_COL_HI: begin
            col_hi <= q_item.arg[3:0];
            column <= {q_item.arg[3:0], col_lo};
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/mono_lcd_controller.sv =====
// ----------------------------------------------------------------------------
// mono_lcd_controller: 128x64 monochrome page-mode LCD controller
// Command, data and pixel read requests over a stream; one pixel per read.
// ----------------------------------------------------------------------------
// Commands and data bytes retire one per cycle once queued, while no clearing
// pass runs; a pixel read passes the queue, the frame store read and the output
// register, and a new read is not taken until the last one has left the store.
// Reset (rst, synchronous) and command 0xE2 start a clearing pass that zeroes
// every frame store byte, during which no transaction is accepted on the input.
// panel_flip is cleared by rst only and is written through cfg_we/cfg_data.
`timescale 1ns / 1ps
`default_nettype none

module mono_lcd_controller #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration: panel_flip register.
  input  wire logic        cfg_we,
  input  wire logic        cfg_data,
  // Request stream.
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [23:0] s_tdata,  // [7:0] byte_value, [14:8] pixel_x,
                                     // [20:15] pixel_y, [23:21] zero
  input  wire logic [1:0]  s_tuser,  // [1:0] req_type
  // Pixel result stream.
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [7:0]  m_tdata   // [0] pixel_on, [7:1] zero
);

  import mcl_pkg::*;

  logic         panel_flip;
  logic         busy_clear;
  logic         q_valid;
  logic         q_ready;
  mcl_item_t    q_item;
  mcl_ram_req_t ram_req;
  logic [7:0]   ram_rdata;
  logic         pix_on;

  // The panel wiring register sits outside the command state, so the
  // software reset command leaves it alone.
  always_ff @(posedge clk) begin
    if (rst) begin
      panel_flip <= 1'b0;
    end else if (cfg_we) begin
      panel_flip <= cfg_data;
    end
  end

  // Front: accepts each transaction, decodes command bytes and queues all but reserved requests.
  mcl_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .busy_clear (busy_clear),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_ready    (q_ready)
  );

  // Back: executes requests in order against the state and frame store.
  mcl_back u_back (
    .clk        (clk),
    .rst        (rst),
    .panel_flip (panel_flip),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_ready    (q_ready),
    .busy_clear (busy_clear),
    .ram_req    (ram_req),
    .ram_rdata  (ram_rdata),
    .pix_valid  (m_tvalid),
    .pix_on     (pix_on),
    .pix_ready  (m_tready)
  );

  // Frame store: byte address is page * 128 + column.
  mcl_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_frame (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  assign m_tdata = {7'd0, pix_on};

endmodule

`default_nettype wire

// ===== design/mcl_checker.sv =====
// ----------------------------------------------------------------------------
// mcl_checker: port-level checks for the LCD controller
// Watches the top-level ports over time; attached by a bind statement.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mcl_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_tready,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata
);

  // Reset starts the clearing pass, so the input is closed right after.
  a_closed_after_reset: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("input ready right after reset");

  // No result may survive a reset.
  a_no_result_after_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // A stalled result holds its value.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // Only the pixel bit of the result may be set.
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[7:1] == 7'd0)
    else $error("result padding not zero");

endmodule

bind mono_lcd_controller mcl_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
